FILE: src/pbs_pkg.sv
`default_nettype none

package pbs_pkg;

  localparam int unsigned NowW      = 16;
  localparam int unsigned SpeedW    = 10;
  localparam int unsigned CourseW   = 9;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned IvalW     = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned DivStepsPerCycle = 2;

  localparam logic [IvalW-1:0]   StatusMinSec = 11'd8;
  localparam logic [IvalW:0]     StatusMaxSec = 12'd1800;
  localparam logic [NowW-1:0]    FollowShift  = 16'd4;
  localparam logic [8:0]         TurnMinDeg   = 9'd20;
  localparam logic [8:0]         TurnMaxDeg   = 9'd80;
  localparam logic [15:0]        TurnSlopeNum = 16'd250;
  localparam logic [NowW-1:0]    TurnDeadSec  = 16'd5;
  localparam logic [CourseW-1:0] HalfCircle   = 9'd180;
  localparam logic [CourseW-1:0] FullCircle   = 9'd360;

  localparam logic [CfgIdxW-1:0] RegFixedInterval = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLowSpeed      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHighSpeed     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFastRate      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlowRate      = 3'd4;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE     = 2'd0,
    CMD_STATUS   = 2'd1,
    CMD_POSITION = 2'd2
  } cmd_e;

  typedef enum logic {
    SEL_RATE = 1'b0,
    SEL_TURN = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_e div_sel;
    logic     decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: src/pbs_div.sv
`default_nettype none

module pbs_div
  import pbs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [15:0]       dividend_i,
  input  wire logic [SpeedW-1:0] divisor_i,
  output logic [15:0]            quotient_o,
  output logic                   done_o
);

  localparam int unsigned Iters = 16 / DivStepsPerCycle;
  localparam int unsigned CntW  = $clog2(Iters);

  logic [15:0]       dvd_q, dvd_d;
  logic [SpeedW-1:0] rem_q, rem_d;
  logic [SpeedW-1:0] dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;

  // two restoring steps per cycle
  always_comb begin
    logic [SpeedW:0] r;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < DivStepsPerCycle; k++) begin
      r     = {rem_d, dvd_d[15]};
      dvd_d = {dvd_d[14:0], 1'b0};
      if (r >= {1'b0, dsr_q}) begin
        r        = r - {1'b0, dsr_q};
        dvd_d[0] = 1'b1;
      end
      rem_d = r[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 1'b1;
        done_q <= (cnt_q == CntW'(Iters - 1));
        if (cnt_q == CntW'(Iters - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

FILE: src/pbs_dp.sv
`default_nettype none

module pbs_dp
  import pbs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [NowW-1:0]     now_i,
  input  wire logic [SpeedW-1:0]   speed_i,
  input  wire logic [CourseW-1:0]  course_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output cmd_e                     out_cmd_o,
  input  wire ctrl_cmd_t           cmd_i,
  output ctrl_sts_t                sts_o
);

  logic [15:0] fixed_q;
  logic [7:0]  low_q, high_q, fast_q, slow_q;

  logic [NowW-1:0]    status_time_q, status_time_d;
  logic [IvalW-1:0]   status_ival_q, status_ival_d;
  logic [NowW-1:0]    pos_time_q, pos_time_d;
  logic [CourseW-1:0] last_head_q, last_head_d;
  logic               head_known_q, head_known_d;

  logic [NowW-1:0]    now_q;
  logic [SpeedW-1:0]  speed_q;
  logic [CourseW-1:0] course_q;
  logic [NowW-1:0]    st_el_q, pos_el_q;
  logic [15:0]        rate_div_q;
  logic [7:0]         turn_div_q;

  logic        out_valid_q;
  cmd_e        out_cmd_q, cmd_d;
  logic        out_free;
  logic        apply;

  logic [15:0] div_q;
  logic        div_done;
  logic [15:0] dividend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q <= 16'd0;
      low_q   <= 8'd5;
      high_q  <= 8'd90;
      fast_q  <= 8'd60;
      slow_q  <= 8'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFixedInterval: fixed_q <= cfg_data_i;
        RegLowSpeed:      low_q   <= cfg_data_i[7:0];
        RegHighSpeed:     high_q  <= cfg_data_i[7:0];
        RegFastRate:      fast_q  <= cfg_data_i[7:0];
        RegSlowRate:      slow_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign dividend = (cmd_i.div_sel == SEL_RATE) ? 16'(fast_q * high_q) : TurnSlopeNum;

  pbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (speed_q),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q    <= now_i;
      speed_q  <= speed_i;
      course_q <= (course_i >= FullCircle) ? course_i - FullCircle : course_i;
    end
    st_el_q  <= now_q - status_time_q;
    pos_el_q <= now_q - pos_time_q;
    if (div_done && cmd_i.div_sel == SEL_RATE) begin
      rate_div_q <= div_q;
    end
    if (div_done && cmd_i.div_sel == SEL_TURN) begin
      turn_div_q <= div_q[7:0];
    end
  end

  // decision
  always_comb begin
    logic [IvalW:0]    dbl;
    logic [13:0]       slow_rate;
    logic [8:0]        thr_sum;
    logic [8:0]        thresh;
    logic [15:0]       rate;
    logic [CourseW-1:0] base;
    logic [CourseW-1:0] diff;
    logic [CourseW-1:0] turn;
    logic              hit;

    status_time_d = status_time_q;
    status_ival_d = status_ival_q;
    pos_time_d    = pos_time_q;
    last_head_d   = last_head_q;
    head_known_d  = head_known_q;
    cmd_d         = CMD_NONE;

    dbl       = {status_ival_q, 1'b0};
    slow_rate = {slow_q, 6'b0} - {4'b0, slow_q, 2'b0};
    thr_sum   = TurnMinDeg + {1'b0, turn_div_q};
    if (speed_q > {2'b0, high_q}) begin
      thresh = TurnMinDeg;
      rate   = {8'b0, fast_q};
    end else begin
      thresh = (thr_sum > TurnMaxDeg) ? TurnMaxDeg : thr_sum;
      rate   = rate_div_q;
    end
    base = head_known_q ? last_head_q : course_q;
    diff = (course_q >= base) ? course_q - base : base - course_q;
    turn = (diff > HalfCircle) ? FullCircle - diff : diff;
    hit  = ((turn > thresh) && (pos_el_q > TurnDeadSec)) || (pos_el_q > rate);

    if ({5'b0, status_ival_q} < st_el_q) begin
      cmd_d         = CMD_STATUS;
      status_ival_d = (dbl >= StatusMaxSec) ? StatusMaxSec[IvalW-1:0] : dbl[IvalW-1:0];
      status_time_d = now_q;
    end else if (status_time_q != '0 && (status_time_q + FollowShift) == now_q) begin
      cmd_d      = CMD_POSITION;
      pos_time_d = now_q;
    end else if (fixed_q != '0) begin
      if (fixed_q < pos_el_q) begin
        cmd_d      = CMD_POSITION;
        pos_time_d = now_q;
      end
    end else if (speed_q <= {2'b0, low_q}) begin
      if (pos_el_q > {2'b0, slow_rate}) begin
        cmd_d      = CMD_POSITION;
        pos_time_d = now_q;
      end
    end else begin
      head_known_d = 1'b1;
      if (!head_known_q || hit) begin
        last_head_d = course_q;
      end
      if (hit) begin
        cmd_d      = CMD_POSITION;
        pos_time_d = now_q;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign apply    = cmd_i.decide && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_time_q <= '0;
      status_ival_q <= StatusMinSec;
      pos_time_q    <= '0;
      last_head_q   <= '0;
      head_known_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (apply) begin
        status_time_q <= status_time_d;
        status_ival_q <= status_ival_d;
        pos_time_q    <= pos_time_d;
        last_head_q   <= last_head_d;
        head_known_q  <= head_known_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      out_cmd_q <= cmd_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_cmd_o      = out_cmd_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

endmodule

`default_nettype wire

FILE: src/pbs_ctrl.sv
`default_nettype none

module pbs_ctrl
  import pbs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_DIV_TURN,
    ST_DECIDE
  } state_e;

  state_e   state_q;
  logic     start_q;
  div_sel_e sel_q;
  logic     accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      sel_q   <= SEL_RATE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          start_q <= accept;
          if (accept) begin
            state_q <= ST_DIV_RATE;
            sel_q   <= SEL_RATE;
          end
        end
        ST_DIV_RATE: begin
          start_q <= sts_i.div_done;
          if (sts_i.div_done) begin
            state_q <= ST_DIV_TURN;
            sel_q   <= SEL_TURN;
          end
        end
        ST_DIV_TURN: begin
          start_q <= 1'b0;
          if (sts_i.div_done) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          start_q <= 1'b0;
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          start_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.capture   = accept;
  assign cmd_o.div_start = start_q;
  assign cmd_o.div_sel   = sel_q;
  assign cmd_o.decide    = (state_q == ST_DECIDE);

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_DIV_RATE || state_q == ST_DIV_TURN))
    else $error("divider finished outside a division state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DIV_RATE && start_q))
    else $error("accepted word did not start the rate division");

  a_decide_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && sts_i.out_free) |=> (state_q == ST_IDLE))
    else $error("decision did not return to idle");

  a_start_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == ST_DIV_RATE || state_q == ST_DIV_TURN))
    else $error("divider start outside a division state");
`endif

endmodule

`default_nettype wire

FILE: src/position_beacon_scheduler.sv
// position beacon scheduler
// input stream: one word per gps fix (time in seconds, speed, course);
//   s_axis_tready_o is high only while no word is in work
// output stream: one command word per input word, in order
//   (none, status beacon, position beacon)
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//   write only while no word is in work; unknown indexes are dropped
// schedule: the shared divider runs twice per word at two quotient bits a cycle
//   (rate quotient, then turn threshold quotient), between capture and decide;
//   the next word is taken only after the decision on this one is applied
// reset: clears scheduler state and loads the default configuration
// stall: a finished command waits in the output register; the next input
//   word is taken meanwhile, and its decision waits until that register frees
`default_nettype none

module position_beacon_scheduler
  import pbs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // now_sec [15:0], speed [25:16], course_deg [34:26], zero [39:35]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // command [1:0], zero [7:2]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  cmd_e      out_cmd;

  pbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .now_i       (s_axis_tdata_i[15:0]),
    .speed_i     (s_axis_tdata_i[25:16]),
    .course_i    (s_axis_tdata_i[34:26]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_cmd_o   (out_cmd),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata_o = {{(OutDataW - CmdW){1'b0}}, out_cmd};

endmodule

`default_nettype wire
